// ----- hw/rtl/rsa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsa_pkg
// shared types and constants of the stack calculator core
// ----------------------------------------------------------------------------
package rsa_pkg;

  localparam int unsigned StackDepthDef = 16;
  localparam int unsigned FracBitsDef   = 16;
  localparam int unsigned ValW          = 32;

  typedef enum logic [2:0] {
    KIND_PUSH = 3'd0,
    KIND_POP  = 3'd1,
    KIND_ADD  = 3'd2,
    KIND_SUB  = 3'd3,
    KIND_MUL  = 3'd4,
    KIND_DIV  = 3'd5,
    KIND_SQRT = 3'd6,
    KIND_PEEK = 3'd7
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_UNDER = 3'd1,
    ST_DIVZ  = 3'd2,
    ST_NEGSQ = 3'd3,
    ST_OVF   = 3'd4,
    ST_FULL  = 3'd5
  } status_e;

  typedef struct packed {
    logic [2:0]        kind;
    logic signed [31:0] value;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] top_value;
    logic               top_valid;
    logic [4:0]         entry_count;
  } out_beat_t;

  // controller to datapath
  typedef struct packed {
    logic rd_y;     // read top entry into y
    logic rd_x;     // read entry below top into x
    logic alu_go;   // start arithmetic on x, y
    logic wr_push;  // write input value at count
    logic wr_res;   // write result at count-1, count already updated
    logic rd_top;   // read new top for result; never driven, the datapath reads the top by default
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic alu_done;
    logic alu_err;
    logic [2:0] alu_status;
  } sts_t;

endpackage

// ----- hw/rtl/rsa_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsa_datapath
// stack memory, operand registers and iterative arithmetic unit
// ----------------------------------------------------------------------------
module rsa_datapath import rsa_pkg::*; #(
  parameter int unsigned StackDepth = StackDepthDef,
  parameter int unsigned FracBits   = FracBitsDef,
  localparam int unsigned AW = (StackDepth > 1) ? $clog2(StackDepth) : 1,
  localparam int unsigned CW = $clog2(StackDepth + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  input  logic [2:0]         kind_i,
  input  logic signed [31:0] value_i,
  input  logic [CW-1:0]      count_i,
  output sts_t               sts_o,
  output logic signed [31:0] top_o
);

  localparam int unsigned NW  = 32 + FracBits;  // dividend width
  localparam int unsigned SW  = 64;             // sqrt radicand width
  localparam int unsigned DCW = $clog2(NW + 1);

  typedef enum logic [1:0] {
    A_IDLE,
    A_DIV,
    A_SQRT,
    A_MUL
  } alu_e;

  logic signed [31:0] mem_q [StackDepth];
  logic signed [31:0] rd_q;
  logic signed [31:0] x_q, y_q;
  logic [CW-1:0]      wa;
  logic [AW-1:0]      ra;

  // memory port, single write single read
  always_comb begin
    wa = count_i;
    if (cmd_i.wr_res) begin
      wa = count_i - CW'(1);
    end
    ra = AW'(count_i - CW'(1));
    // read of x is issued while y is captured
    if (cmd_i.rd_y || cmd_i.rd_x) ra = AW'(count_i - CW'(2));
  end

  logic signed [31:0] res_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_push) mem_q[AW'(wa)] <= value_i;
    else if (cmd_i.wr_res) mem_q[AW'(wa)] <= res_q;
    // result written to the entry being read is passed straight through
    if (cmd_i.wr_res && (AW'(wa) == ra)) rd_q <= res_q;
    else rd_q <= mem_q[ra];
  end
  assign top_o = rd_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_y) y_q <= rd_q;
    if (cmd_i.rd_x) x_q <= rd_q;
  end

  // arithmetic unit
  alu_e              st_q;
  logic [NW-1:0]     num_q;   // dividend bits
  logic [NW-1:0]     rem_q;
  logic [NW-1:0]     quo_q;
  logic [31:0]       den_q;
  logic [DCW-1:0]    cnt_q;
  logic              neg_q;
  logic [SW-1:0]     sn_q, sres_q, sbit_q;
  logic signed [63:0] prod_q;
  logic              done_q, err_q;
  logic [2:0]        stat_q;

  logic signed [32:0] sum;
  logic [NW:0]        rtry;
  logic [31:0]        mx, my;
  logic signed [63:0] psh;
  logic [NW:0]        qlim;

  always_comb begin
    sum  = (kind_i == KIND_ADD) ? 33'(x_q) + 33'(y_q) : 33'(x_q) - 33'(y_q);
    rtry = {rem_q, num_q[NW-1]} - {(NW+1-32)'(0), den_q};
    mx   = x_q[31] ? 32'(-x_q) : 32'(x_q);
    my   = y_q[31] ? 32'(-y_q) : 32'(y_q);
    psh  = prod_q >>> FracBits;
    qlim = neg_q ? (NW+1)'(33'h0_8000_0000) : (NW+1)'(33'h0_7FFF_FFFF);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= A_IDLE;
      done_q <= 1'b0;
      err_q  <= 1'b0;
      stat_q <= ST_OK;
    end else begin
      done_q <= 1'b0;
      case (st_q)
        A_IDLE: begin
          if (cmd_i.alu_go) begin
            case (kind_i)
              KIND_ADD, KIND_SUB: begin
                res_q  <= sum[31:0];
                err_q  <= (sum[32] != sum[31]);
                stat_q <= (sum[32] != sum[31]) ? ST_OVF : ST_OK;
                done_q <= 1'b1;
              end
              KIND_MUL: begin
                prod_q <= 64'(x_q) * 64'(y_q);
                st_q   <= A_MUL;
              end
              KIND_DIV: begin
                if (y_q == 32'sd0) begin
                  err_q  <= 1'b1;
                  stat_q <= ST_DIVZ;
                  done_q <= 1'b1;
                end else begin
                  num_q <= NW'(mx) << FracBits;
                  den_q <= my;
                  rem_q <= '0;
                  quo_q <= '0;
                  neg_q <= x_q[31] ^ y_q[31];
                  cnt_q <= DCW'(NW);
                  st_q  <= A_DIV;
                end
              end
              default: begin  // sqrt
                if (y_q[31]) begin
                  err_q  <= 1'b1;
                  stat_q <= ST_NEGSQ;
                  done_q <= 1'b1;
                end else begin
                  sn_q   <= SW'(y_q) << FracBits;
                  sres_q <= '0;
                  sbit_q <= SW'(1) << (SW - 2);
                  st_q   <= A_SQRT;
                end
              end
            endcase
          end
        end
        A_MUL: begin
          res_q  <= psh[31:0];
          err_q  <= (psh > 64'sh7FFF_FFFF) || (psh < -64'sh8000_0000);
          stat_q <= ((psh > 64'sh7FFF_FFFF) || (psh < -64'sh8000_0000)) ? ST_OVF : ST_OK;
          done_q <= 1'b1;
          st_q   <= A_IDLE;
        end
        A_DIV: begin
          // one quotient bit a cycle, restoring
          num_q <= num_q << 1;
          if (!rtry[NW]) begin
            rem_q <= rtry[NW-1:0];
            quo_q <= {quo_q[NW-2:0], 1'b1};
          end else begin
            rem_q <= {rem_q[NW-2:0], num_q[NW-1]};
            quo_q <= {quo_q[NW-2:0], 1'b0};
          end
          cnt_q <= cnt_q - DCW'(1);
          if (cnt_q == DCW'(0)) begin
            err_q  <= {1'b0, quo_q} > qlim;
            stat_q <= ({1'b0, quo_q} > qlim) ? ST_OVF : ST_OK;
            res_q  <= neg_q ? 32'(-quo_q[31:0]) : quo_q[31:0];
            done_q <= 1'b1;
            st_q   <= A_IDLE;
          end
        end
        A_SQRT: begin
          // two radicand bits a cycle
          if (sbit_q == '0) begin
            res_q  <= sres_q[31:0];
            err_q  <= 1'b0;
            stat_q <= ST_OK;
            done_q <= 1'b1;
            st_q   <= A_IDLE;
          end else begin
            if (sn_q >= sres_q + sbit_q) begin
              sn_q   <= sn_q - (sres_q + sbit_q);
              sres_q <= (sres_q >> 1) + sbit_q;
            end else begin
              sres_q <= sres_q >> 1;
            end
            sbit_q <= sbit_q >> 2;
          end
        end
        default: st_q <= A_IDLE;
      endcase
    end
  end

  assign sts_o.alu_done   = done_q;
  assign sts_o.alu_err    = err_q;
  assign sts_o.alu_status = stat_q;

endmodule

// ----- hw/rtl/rsa_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsa_ctrl
// sequencer for one opcode at a time, owns the entry count
// ----------------------------------------------------------------------------
module rsa_ctrl import rsa_pkg::*; #(
  parameter int unsigned StackDepth = StackDepthDef,
  localparam int unsigned CW = $clog2(StackDepth + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  in_beat_t           in_beat_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_beat_t          out_beat_o,
  output cmd_t               cmd_o,
  output logic [2:0]         kind_o,
  output logic signed [31:0] value_o,
  output logic [CW-1:0]      count_o,
  input  sts_t               sts_i,
  input  logic signed [31:0] top_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RDY,
    S_RDX,
    S_GO,
    S_WAIT,
    S_TOP,
    S_TOPW,
    S_OUT
  } state_e;

  state_e         st_q;
  logic [2:0]     kind_q;
  logic signed [31:0] val_q;
  logic [CW-1:0]  cnt_q;
  logic [2:0]     stat_q;
  out_beat_t      ob_q;
  cmd_t           cmd_q;

  assign in_ready_o  = (st_q == S_IDLE);
  assign out_valid_o = (st_q == S_OUT);
  assign out_beat_o  = ob_q;
  assign cmd_o       = cmd_q;
  assign kind_o      = kind_q;
  assign value_o     = val_q;
  assign count_o     = cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= S_IDLE;
      cnt_q  <= '0;
      cmd_q  <= '0;
      kind_q <= KIND_PEEK;
      val_q  <= '0;
      stat_q <= ST_OK;
      ob_q   <= '0;
    end else begin
      cmd_q <= '0;
      case (st_q)
        S_IDLE: begin
          if (in_valid_i) begin
            kind_q <= in_beat_i.kind;
            val_q  <= in_beat_i.value;
            stat_q <= ST_OK;
            case (in_beat_i.kind)
              KIND_PUSH: begin
                if (cnt_q >= CW'(StackDepth)) begin
                  stat_q <= ST_FULL;
                  st_q   <= S_TOP;
                end else begin
                  cmd_q.wr_push <= 1'b1;
                  st_q          <= S_RDY;
                end
              end
              KIND_POP, KIND_PEEK, KIND_SQRT: begin
                if (cnt_q == '0) begin
                  stat_q <= ST_UNDER;
                  st_q   <= S_TOP;
                end else if (in_beat_i.kind == KIND_SQRT) begin
                  cmd_q.rd_y <= 1'b1;
                  st_q       <= S_RDY;
                end else begin
                  if (in_beat_i.kind == KIND_POP) cnt_q <= cnt_q - CW'(1);
                  st_q <= S_TOP;
                end
              end
              default: begin
                if (cnt_q < CW'(2)) begin
                  stat_q <= ST_UNDER;
                  st_q   <= S_TOP;
                end else begin
                  cmd_q.rd_y <= 1'b1;
                  st_q       <= S_RDY;
                end
              end
            endcase
          end
        end
        S_RDY: begin
          // read data for y lands now, or push write done
          if (kind_q == KIND_PUSH) begin
            cnt_q <= cnt_q + CW'(1);
            st_q  <= S_TOP;
          end else if (kind_q == KIND_SQRT) begin
            st_q <= S_GO;
          end else begin
            cmd_q.rd_x <= 1'b1;
            st_q       <= S_RDX;
          end
        end
        S_RDX: st_q <= S_GO;
        S_GO: begin
          cmd_q.alu_go <= 1'b1;
          st_q         <= S_WAIT;
        end
        S_WAIT: begin
          if (sts_i.alu_done) begin
            stat_q <= sts_i.alu_status;
            if (sts_i.alu_err) begin
              cnt_q <= (kind_q == KIND_SQRT) ? cnt_q - CW'(1) : cnt_q - CW'(2);
            end else begin
              cmd_q.wr_res <= 1'b1;
              if (kind_q != KIND_SQRT) cnt_q <= cnt_q - CW'(1);
            end
            st_q <= S_TOP;
          end
        end
        S_TOP: st_q <= S_TOPW;  // count settled, top read issued
        S_TOPW: begin
          ob_q.status      <= stat_q;
          ob_q.top_valid   <= (cnt_q != '0);
          ob_q.top_value   <= (cnt_q != '0) ? top_i : 32'sd0;
          ob_q.entry_count <= 5'(cnt_q);
          st_q             <= S_OUT;
        end
        S_OUT: begin
          if (out_ready_i) st_q <= S_IDLE;
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- hw/rtl/rpn_stack_alu.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_stack_alu
// stack calculator core on signed fixed-point values
// ----------------------------------------------------------------------------
// one opcode a beat, one result beat back with status, new top and count.
// items are handled one at a time: the next opcode is taken only after the
// result beat of the last one has been accepted. pop, peek, push and every
// underflow or full report bypass the arithmetic unit; sqrt works two
// radicand bits a cycle over 64 bits and div uses a restoring divider that
// produces one quotient bit a cycle. a stalled result side holds off the
// next opcode. the stack lives in a single-port-write, single-read memory;
// only entries below the count are used, so no clearing pass is needed
// after reset.
module rpn_stack_alu import rsa_pkg::*; #(
  parameter int unsigned StackDepth = StackDepthDef,
  parameter int unsigned FracBits   = FracBitsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_beat_t  in_beat_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_beat_t out_beat_o
);

  localparam int unsigned CW = $clog2(StackDepth + 1);

  // command and status between sequencer and datapath
  cmd_t               cmd;
  sts_t               sts;
  logic [2:0]         kind;
  logic signed [31:0] value;
  logic [CW-1:0]      count;
  logic signed [31:0] top;

  rsa_ctrl #(.StackDepth(StackDepth)) u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_beat_i,
    .out_valid_o, .out_ready_i, .out_beat_o,
    .cmd_o(cmd), .kind_o(kind), .value_o(value), .count_o(count),
    .sts_i(sts), .top_i(top)
  );

  rsa_datapath #(.StackDepth(StackDepth), .FracBits(FracBits)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .kind_i(kind), .value_i(value),
    .count_i(count), .sts_o(sts), .top_o(top)
  );

endmodule

// ----- hw/rtl/rsa_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsa_checker
// port-level checks of the stack calculator core
// ----------------------------------------------------------------------------
module rsa_checker import rsa_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input out_beat_t out_beat_o,
  input logic      out_valid_o,
  input logic      out_ready_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_beat_o))
    else $error("result beat dropped");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input taken while result pending");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second beat taken while busy");

  a_valid_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_beat_o.top_valid == (out_beat_o.entry_count != 5'd0)))
    else $error("top_valid disagrees with count");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_beat_o.status <= ST_FULL)
    else $error("status code out of range");

endmodule

bind rpn_stack_alu rsa_checker u_chk (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_beat_o, .out_valid_o, .out_ready_i
);

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// checks the stack calculator core against an in-bench calculator model
// ----------------------------------------------------------------------------
// opcode beats go in through a valid/ready sender; result beats are compared
// field by field with a queue of predicted results. phases vary the idling of
// both sides; one phase holds the result side off for a long stretch.
module testbench;
  import rsa_pkg::*;

  localparam int Depth = StackDepthDef;
  localparam int Frac  = FracBitsDef;
  localparam int WatchdogLimit = 20000;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_beat_t  in_beat_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_beat_t out_beat_o;

  rpn_stack_alu uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_beat_i(in_beat_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_beat_o(out_beat_o)
  );

  // model of the calculator stack
  logic signed [31:0] calc_stack [Depth];
  int unsigned        calc_count;
  out_beat_t          pending_results [$];

  int  error_count;
  int  beats_sent;
  int  beats_checked;
  int  send_idle_pct;
  int  recv_stall_pct;
  int  hold_off_cycles;
  int  idle_cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [63:0] int_sqrt(logic [63:0] n);
    logic [63:0] res;
    logic [63:0] bitv;
    res  = '0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n   = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // works out the result beat of one opcode and updates the model stack
  function automatic out_beat_t calc_result(in_beat_t beat);
    out_beat_t r;
    status_e st;
    longint x, y, res;
    logic [63:0] mx, my, q;
    logic neg;
    st = ST_OK;
    case (kind_e'(beat.kind))
      KIND_PUSH: begin
        if (calc_count >= Depth) st = ST_FULL;
        else begin
          calc_stack[calc_count] = beat.value;
          calc_count++;
        end
      end
      KIND_POP, KIND_PEEK: begin
        if (calc_count == 0) st = ST_UNDER;
        else if (kind_e'(beat.kind) == KIND_POP) calc_count--;
      end
      KIND_SQRT: begin
        if (calc_count == 0) st = ST_UNDER;
        else begin
          y = calc_stack[calc_count-1];
          if (y < 0) begin
            st = ST_NEGSQ;
            calc_count--;
          end else begin
            calc_stack[calc_count-1] = 32'(int_sqrt(64'(y) << Frac));
          end
        end
      end
      default: begin
        if (calc_count < 2) st = ST_UNDER;
        else begin
          y = calc_stack[calc_count-1];
          x = calc_stack[calc_count-2];
          calc_count -= 2;
          res = 0;
          case (kind_e'(beat.kind))
            KIND_ADD: res = x + y;
            KIND_SUB: res = x - y;
            KIND_MUL: res = (x * y) >>> Frac; // arithmetic shift floors
            default: begin
              if (y == 0) st = ST_DIVZ;
              else begin
                mx  = (x < 0) ? -x : x;
                my  = (y < 0) ? -y : y;
                q   = (mx << Frac) / my;
                neg = (x < 0) != (y < 0);
                res = neg ? -longint'(q) : longint'(q);
                if (q > 64'h8000_0000) res = 64'h1_0000_0000; // force overflow
              end
            end
          endcase
          if (st == ST_OK) begin
            if (res > 64'sd2147483647 || res < -64'sd2147483648) st = ST_OVF;
            else begin
              calc_stack[calc_count] = res[31:0];
              calc_count++;
            end
          end
        end
      end
    endcase
    r.status      = st;
    r.top_valid   = calc_count > 0;
    r.top_value   = calc_count > 0 ? calc_stack[calc_count-1] : '0;
    r.entry_count = calc_count[4:0];
    return r;
  endfunction

  // sends one beat and records its predicted result on acceptance
  task automatic send_beat(kind_e k, logic signed [31:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_beat_i  <= '{kind: k, value: v};
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.push_back(calc_result('{kind: k, value: v}));
    beats_sent++;
  endtask

  // result side: random stalls, or a long hold-off when requested
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    out_beat_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat %p", $time, out_beat_o);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        beats_checked++;
        if (out_beat_o.status !== want.status) begin
          $display("%0t: status exp %0d got %0d", $time, want.status, out_beat_o.status);
          error_count++;
        end
        if (out_beat_o.top_value !== want.top_value) begin
          $display("%0t: top_value exp %h got %h", $time, want.top_value,
                   out_beat_o.top_value);
          error_count++;
        end
        if (out_beat_o.top_valid !== want.top_valid) begin
          $display("%0t: top_valid exp %b got %b", $time, want.top_valid,
                   out_beat_o.top_valid);
          error_count++;
        end
        if (out_beat_o.entry_count !== want.entry_count) begin
          $display("%0t: entry_count exp %0d got %0d", $time, want.entry_count,
                   out_beat_o.entry_count);
          error_count++;
        end
      end
    end
  end

  // watchdog on cycles with no beat moving on either side
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || !rst_ni)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WatchdogLimit) begin
      $display("watchdog expired at %0t", $time);
      $display("testbench failed");
      $finish;
    end
  end

  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(5))
      0: return 32'sh7fff_ffff;
      1: return 32'sh8000_0000;
      2: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000; // around +-2.0
      3: return $urandom_range(0, 32'h0000_ffff);
      default: return $urandom();
    endcase
  endfunction

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // extremes of values, every opcode and every error path but a full stack
  task automatic test_directed();
    send_beat(KIND_POP, 0);
    send_beat(KIND_PEEK, 0);
    send_beat(KIND_SQRT, 0);
    send_beat(KIND_PUSH, 32'sh7fff_ffff);
    send_beat(KIND_ADD, 0);                  // one operand only
    send_beat(KIND_PUSH, 32'sh0000_0001);
    send_beat(KIND_ADD, 0);                  // overflow
    send_beat(KIND_PUSH, 32'sh8000_0000);
    send_beat(KIND_PUSH, 32'sh0001_0000);
    send_beat(KIND_SUB, 0);                  // overflow on subtract
    send_beat(KIND_PUSH, 32'sh0003_0000);
    send_beat(KIND_PUSH, 32'sh0000_0000);
    send_beat(KIND_DIV, 0);                  // divide by zero
    send_beat(KIND_PUSH, 32'sh8000_0000);
    send_beat(KIND_PUSH, 32'shffff_0000);
    send_beat(KIND_DIV, 0);                  // most negative over -1
    send_beat(KIND_PUSH, 32'shfffe_0000);
    send_beat(KIND_SQRT, 0);                 // negative root
    send_beat(KIND_PUSH, 32'sh7fff_ffff);
    send_beat(KIND_SQRT, 0);
    send_beat(KIND_PUSH, 32'sh7fff_ffff);
    send_beat(KIND_MUL, 0);                  // overflow on multiply
    send_beat(KIND_PUSH, 32'shffff_8000);
    send_beat(KIND_PUSH, 32'sh0000_0001);
    send_beat(KIND_MUL, 0);                  // rounds toward minus infinity
    wait_drained();
  endtask

  // pushes mixed with random other opcodes; pushes favoured while the stack is short or nearly full
  task automatic test_random(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 40 || calc_count < 2 && r < 60) send_beat(KIND_PUSH, rand_value());
      else if (r < 45 && calc_count > Depth - 3)
        send_beat(KIND_PUSH, rand_value());
      else send_beat(kind_e'($urandom_range(1, 7)), $urandom());
    end
  endtask

  // fill to beyond full so the push error is seen, then unwind
  task automatic test_full_stack();
    for (int i = 0; i < Depth + 2; i++) send_beat(KIND_PUSH, rand_value());
    for (int i = 0; i < Depth + 1; i++) send_beat(KIND_POP, 0);
    wait_drained();
  endtask

  // results held off while the sender keeps offering beats
  task automatic test_back_pressure();
    hold_off_cycles = 400;
    test_random(30);
    wait_drained();
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_beat_i = '0;
    error_count = 0;
    beats_sent = 0;
    beats_checked = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_cycles = 0;
    idle_cycles = 0;
    calc_count = 0;
    foreach (calc_stack[i]) calc_stack[i] = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_full_stack();
    // phases: no idling, sender idle, receiver stalling, both
    test_random(280);
    send_idle_pct = 77;
    test_random(260);
    send_idle_pct = 0;
    recv_stall_pct = 77;
    test_random(260);
    send_idle_pct = 26;
    recv_stall_pct = 26;
    test_random(260);
    test_full_stack();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_back_pressure();

    wait_drained();
    repeat (100) @(posedge clk_i);
    $display("sent %0d opcode beats, checked %0d results over all opcodes,",
             beats_sent, beats_checked);
    $display("error paths, a full stack and several idling mixes");
    if (error_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
